/* rtl/pwm_pulse_width_median_filter_defines.svh */
// Assertion macros used by the top level of the pulse-width median filter.
`ifndef PWM_PULSE_WIDTH_MEDIAN_FILTER_DEFINES_SVH
`define PWM_PULSE_WIDTH_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWMF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwmf same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PWMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwmf next-cycle check failed");

`endif

/* rtl/pwmf_pkg.sv */
// Shared types, widths and constants of the pulse-width median filter.
package pwmf_pkg;

  // Fixed field widths.
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned WIDTH_W = 26;

  // Defaults for the top-level parameters.
  localparam int unsigned WINDOW_LEN_DEF   = 11;
  localparam int unsigned TICKS_PER_US_DEF = 80;

  // Reset value of the acceptance limit.
  localparam logic [WIDTH_W-1:0] LIMIT_RESET = 26'd4166;

  // Queue between the capture front and the filter back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    EDGE_RISE = 1'b0,
    EDGE_FALL = 1'b1
  } edge_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic div_step;
    logic win_write;
    logic scan_step;
    logic emit;
  } back_ctl_t;

endpackage

/* rtl/pwmf_channels.sv */
// Valid/ready channel interfaces for edge events and filter results.
interface pwmf_in_if;
  import pwmf_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [STAMP_W-1:0] capture_time;

  modport source (output valid, op, capture_time, input ready);
  modport sink   (input valid, op, capture_time, output ready);
endinterface

interface pwmf_out_if;
  import pwmf_pkg::*;
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] median_width;
  logic               accepted;
  logic [WIDTH_W-1:0] held_width;

  modport source (output valid, median_width, accepted, held_width, input ready);
  modport sink   (input valid, median_width, accepted, held_width, output ready);
endinterface

/* rtl/pwmf_front.sv */
// Edge capture front: keeps the rising stamp and queues raw pulse lengths.
module pwmf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  pwmf_in_if.sink                     in_ch,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [pwmf_pkg::STAMP_W-1:0] q_push_data
);
  import pwmf_pkg::*;

  logic [STAMP_W-1:0] rise_stamp_r;
  logic               in_fire;

  // A beat is taken whenever the queue has room for a falling edge.
  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Falling edges push the wrapping tick difference to the back end.
  assign q_push      = in_fire && (in_ch.op == EDGE_FALL);
  assign q_push_data = in_ch.capture_time - rise_stamp_r;

  // Rising edges overwrite the stored stamp.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_stamp_r <= '0;
    end else if (in_fire && (in_ch.op == EDGE_RISE)) begin
      rise_stamp_r <= in_ch.capture_time;
    end
  end

endmodule

/* rtl/pwmf_queue.sv */
// Small FIFO of tick differences between the front and the back end.
module pwmf_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [pwmf_pkg::STAMP_W-1:0] push_data,
  output logic                         full,
  input  logic                         pop,
  output logic                         valid,
  output logic [pwmf_pkg::STAMP_W-1:0] pop_data
);
  import pwmf_pkg::*;

  logic [STAMP_W-1:0] entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  head_r;
  logic [QPTR_W-1:0]  tail_r;
  logic [QCNT_W-1:0]  count_r;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = entry_r[head_r];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        tail_r <= (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      end
      if (pop) begin
        head_r <= (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[tail_r] <= push_data;
    end
  end

endmodule

/* rtl/pwmf_back.sv */
// Filter back end: divides to microseconds, updates the window, finds the median.
module pwmf_back #(
  parameter int unsigned WINDOW_LEN   = pwmf_pkg::WINDOW_LEN_DEF,
  parameter int unsigned TICKS_PER_US = pwmf_pkg::TICKS_PER_US_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pwmf_pkg::WIDTH_W-1:0] cfg_wdata,
  input  logic                         q_valid,
  input  logic [pwmf_pkg::STAMP_W-1:0] q_data,
  output logic                         q_pop,
  pwmf_out_if.source                   out_ch
);
  import pwmf_pkg::*;

  localparam int unsigned SLOT_W   = $clog2(WINDOW_LEN);
  localparam int unsigned RANK_W   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned MED_IDX  = WINDOW_LEN / 2;
  localparam int unsigned RECIP_SH = STAMP_W + $clog2(TICKS_PER_US);

  // Rounded-up reciprocal of the tick rate; exact for every 32-bit dividend.
  localparam logic [STAMP_W:0] RECIP = (STAMP_W + 1)'(
    ((64'd1 << RECIP_SH) + 64'(TICKS_PER_US) - 64'd1) / 64'(TICKS_PER_US));

  localparam logic [SLOT_W-1:0]     SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
  localparam logic [RANK_W-1:0]     MED_RANK  = RANK_W'(MED_IDX);

  back_state_t        state_r, state_nxt;
  back_ctl_t          ctl;

  logic [WIDTH_W-1:0] limit_r;
  logic [WIDTH_W-1:0] held_r;
  logic [WIDTH_W-1:0] window_r [WINDOW_LEN];
  logic [SLOT_W-1:0]  slot_r;
  logic [WIDTH_W-1:0] scan_r [WINDOW_LEN];
  logic [SLOT_W-1:0]  cand_r;
  logic [WIDTH_W-1:0] med_r;

  logic [STAMP_W-1:0]   dq_r;
  logic [STAMP_W-1:0]   quot_r;
  logic [2*STAMP_W:0]   prod;

  logic [WIDTH_W-1:0] width_sat;
  logic [RANK_W-1:0]  rank;
  logic               found;
  logic               take;
  logic               out_free;

  logic               out_valid_r;
  logic [WIDTH_W-1:0] out_med_r;
  logic               out_acc_r;
  logic [WIDTH_W-1:0] out_held_r;

  // Division by the tick rate as one multiply by the reciprocal.
  assign prod = dq_r * RECIP;

  // Quotients beyond the field width saturate.
  assign width_sat = (|quot_r[STAMP_W-1:WIDTH_W]) ? '1 : quot_r[WIDTH_W-1:0];

  // Stable rank of the current candidate: smaller entries plus equal
  // entries that sit at a lower slot.
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      if ((window_r[j] < scan_r[0]) ||
          ((window_r[j] == scan_r[0]) && (SLOT_W'(j) < cand_r))) begin
        rank = rank + 1'b1;
      end
    end
  end

  assign found    = (rank == MED_RANK);
  assign take     = (med_r < limit_r);
  assign out_free = !out_valid_r || out_ch.ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid)                state_nxt = ST_DIV;
      ST_DIV:                              state_nxt = ST_LOAD;
      ST_LOAD:                             state_nxt = ST_SCAN;
      ST_SCAN: if (found)                  state_nxt = ST_EMIT;
      ST_EMIT: if (out_free)               state_nxt = ST_IDLE;
      default:                             state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: ctl.pop       = q_valid;
      ST_DIV:  ctl.div_step  = 1'b1;
      ST_LOAD: ctl.win_write = 1'b1;
      ST_SCAN: ctl.scan_step = 1'b1;
      ST_EMIT: ctl.emit      = out_free;
      default: ctl           = '0;
    endcase
  end

  assign q_pop = ctl.pop;

  // Control state, register, window and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      held_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        window_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (ctl.win_write) begin
        window_r[slot_r] <= width_sat;
        slot_r           <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
      end
      if (ctl.emit && take) begin
        held_r <= med_r;
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      dq_r <= q_data;
    end
    if (ctl.div_step) begin
      quot_r <= STAMP_W'(prod >> RECIP_SH);
    end
    // Snapshot the window with the new width in place.
    if (ctl.win_write) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        scan_r[k] <= (SLOT_W'(k) == slot_r) ? width_sat : window_r[k];
      end
      cand_r <= '0;
    end
    // Rotate candidates through the head of the scan line.
    if (ctl.scan_step) begin
      if (found) begin
        med_r <= scan_r[0];
      end
      for (int k = 0; k < WINDOW_LEN - 1; k++) begin
        scan_r[k] <= scan_r[k + 1];
      end
      scan_r[WINDOW_LEN - 1] <= scan_r[0];
      cand_r <= cand_r + 1'b1;
    end
    if (ctl.emit) begin
      out_med_r  <= med_r;
      out_acc_r  <= take;
      out_held_r <= take ? med_r : held_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.median_width = out_med_r;
  assign out_ch.accepted     = out_acc_r;
  assign out_ch.held_width   = out_held_r;

endmodule

/* rtl/pwm_pulse_width_median_filter.sv */
// Top level of the PWM pulse-width capture with sliding median filter.
//
//   channel   direction  handshake        beat contents
//   in_ch     in         valid/ready      op, capture_time
//   out_ch    out        valid/ready      median_width, accepted, held_width
//   cfg_*     in         write enable     accept_limit
//
// A rising edge is absorbed by the front alone. A falling edge costs a queue pop,
// a reciprocal multiply, a window write, a median scan that rotates candidates
// until the median is found, and a result stage that holds while out_ch is not ready.
// The scan checks one candidate per cycle; no new width is popped until the result is emitted.
// A two-entry queue lets edge beats keep arriving while a result waits on out_ch.
// Reset is synchronous and active low; the window clears at once, with no sweep.
module pwm_pulse_width_median_filter #(
  parameter int unsigned WINDOW_LEN   = pwmf_pkg::WINDOW_LEN_DEF,
  parameter int unsigned TICKS_PER_US = pwmf_pkg::TICKS_PER_US_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pwmf_in_if.sink                      in_ch,
  pwmf_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [pwmf_pkg::WIDTH_W-1:0] cfg_wdata
);
  import pwmf_pkg::*;
  `include "pwm_pulse_width_median_filter_defines.svh"

  logic               q_push;
  logic [STAMP_W-1:0] q_push_data;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  logic [STAMP_W-1:0] q_data;

  // Edge capture.
  pwmf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Decoupling queue.
  pwmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  // Width conversion and median filter.
  pwmf_back #(
    .WINDOW_LEN   (WINDOW_LEN),
    .TICKS_PER_US (TICKS_PER_US)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

  // The front never pushes into a full queue.
  `PWMF_ASSERT_IMPL(a_queue_no_overflow, clk, rst_n, q_push, !q_full)
  // A falling-edge beat is waiting in the queue on the next cycle.
  `PWMF_ASSERT_NEXT(a_fall_queued, clk, rst_n, q_push, q_valid)
  // An accepted median is the held width reported with it.
  `PWMF_ASSERT_IMPL(a_held_follows, clk, rst_n, out_ch.valid && out_ch.accepted, out_ch.held_width == out_ch.median_width)

endmodule
